// ----- rtl/sm4cm_pkg.sv -----
// Package for the SM4 CBC-MAC engine: widths, codes, S-box and cipher helper functions.
`timescale 1ns / 1ps
package sm4cm_pkg;

	localparam int BLOCK_BYTES_DEF = 16;
	localparam int ROUNDS = 32;
	localparam int RK_AW = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 64;

	typedef enum logic {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} opcode_t;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEXP,
		ST_LOAD,
		ST_ROUND,
		ST_STORE,
		ST_OUT
	} state_t;

	// Request from the controller to the cipher round unit.
	typedef struct packed {
		logic start_enc;
		logic start_kexp;
	} core_cmd_t;

	localparam logic [31:0] FK0 = 32'ha3b1bac6;
	localparam logic [31:0] FK1 = 32'h56aa3350;
	localparam logic [31:0] FK2 = 32'h677d9197;
	localparam logic [31:0] FK3 = 32'hb27022dc;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] tau(input logic [31:0] a);
		tau = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	// Round constant: byte j of word i is (4i+j)*7 mod 256.
	function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
		logic [7:0] b0;
		b0 = {1'b0, i, 2'b00} * 8'd7;
		ck_word = {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
	endfunction

endpackage

// ----- rtl/sm4cm_round.sv -----
// Shared SM4 round unit: one round per cycle, for encryption or key expansion.
`timescale 1ns / 1ps
module sm4cm_round
	import sm4cm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic         kexp,
	input  logic         step,
	input  logic [127:0] init,
	input  logic [31:0]  rk,
	input  logic [RK_AW-1:0] rnd,
	output logic [31:0]  new_word,
	output logic [127:0] state
);

	logic [31:0] x0_q, x1_q, x2_q, x3_q;
	logic        kexp_q;
	logic [31:0] b;
	logic [31:0] mix;

	always_comb begin
		mix = x1_q ^ x2_q ^ x3_q ^ (kexp_q ? ck_word(rnd) : rk);
		b = tau(mix);
		if (kexp_q) begin
			new_word = x0_q ^ b ^ rotl(b, 13) ^ rotl(b, 23);
		end else begin
			new_word = x0_q ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kexp_q <= 1'b0;
		end else if (load) begin
			kexp_q <= kexp;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			{x0_q, x1_q, x2_q, x3_q} <= init;
		end else if (step) begin
			{x0_q, x1_q, x2_q, x3_q} <= {x1_q, x2_q, x3_q, new_word};
		end
	end

	// The output block is the reversed word order after the last round.
	assign state = {x3_q, x2_q, x1_q, x0_q};

endmodule

// ----- rtl/sm4_cbc_mac_engine.sv -----
// Top level of the SM4 CBC-MAC engine: controller, chaining and round-key memories.
//
// Usage: items arrive on valid/ready with opcode and data_byte. An absorb item XORs
// its byte into the chaining block; the sixteenth byte starts an encryption. A finish
// item encrypts a partial block if there is one and then offers mac_high/mac_low on
// out_valid until out_ready takes it; the chaining block and fill count then clear.
// An absorb item's chaining block is read at acceptance and written back in the next cycle;
// a full block then goes through loading the block, 32 rounds and writing it back, in
// the single shared round unit with the one-word round-key memory port. A finish
// with a partial block left runs it through load, rounds and write-back before
// out_valid rises; on a block boundary it goes from idle straight to the output state.
// A new byte is not taken while the last one is written back or a block is encrypted.
// Key writes on cfg_we re-expand the 32 round keys; the block is busy meanwhile.
// After reset the zero key is expanded first (in_ready low).
// While the result waits for out_ready no new item is taken.
`timescale 1ns / 1ps
module sm4_cbc_mac_engine
	import sm4cm_pkg::*;
#(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [7:0]            data_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           mac_high,
	output logic [63:0]           mac_low,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int FW = $clog2(BLOCK_BYTES);

	state_t state_q, state_d;
	logic [63:0] key_high_q, key_low_q;
	logic        kexp_pend_q;
	logic [FW-1:0] fill_q;
	logic [RK_AW-1:0] rnd_q;
	logic          fin_q;
	logic          byte_ph_q;
	logic [7:0]    byte_q;

	// Chaining block: 16 byte lanes read as one word; a zero flag models the clear.
	// A write in the same cycle is forwarded to the read register.
	logic [127:0] chain_mem [1];
	logic [127:0] chain_rd_s1;
	logic         chain_zero_q;
	logic         chain_we;
	logic [127:0] chain_wd;

	logic [31:0] rk_mem [ROUNDS];
	logic [31:0] rk_rd_s1;
	logic        rk_we;
	logic [RK_AW-1:0] rk_ra;

	logic        c_load, c_kexp, c_step;
	logic [127:0] c_init;
	logic [31:0] c_word;
	logic [127:0] c_state;
	logic [127:0] chain_cur;

	always_ff @(posedge clk) begin
		if (chain_we) begin
			chain_mem[0] <= chain_wd;
		end
		chain_rd_s1 <= chain_we ? chain_wd : chain_mem[0];
	end

	always_ff @(posedge clk) begin
		if (rk_we) begin
			rk_mem[rnd_q] <= c_word;
		end
		rk_rd_s1 <= rk_mem[rk_ra];
	end

	assign chain_cur = chain_zero_q ? '0 : chain_rd_s1;

	sm4cm_round u_round (
		.clk(clk), .arst_n(arst_n), .load(c_load), .kexp(c_kexp), .step(c_step),
		.init(c_init), .rk(rk_rd_s1), .rnd(rnd_q), .new_word(c_word), .state(c_state)
	);

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		c_load = 1'b0;
		c_kexp = 1'b0;
		c_step = 1'b0;
		c_init = chain_cur;
		chain_we = 1'b0;
		chain_wd = c_state;
		rk_we = 1'b0;
		rk_ra = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (kexp_pend_q && !cfg_we) begin
					c_load = 1'b1;
					c_kexp = 1'b1;
					c_init = {key_high_q ^ {FK0, FK1}, key_low_q ^ {FK2, FK3}};
					state_d = ST_KEXP;
				end else if (byte_ph_q) begin
					// Read data for the absorb is now valid: modify and write back.
					chain_we = 1'b1;
					chain_wd = chain_cur ^ ({120'd0, byte_q}
						<< (8 * (BLOCK_BYTES - 1 - int'(fill_q))));
					if (fill_q == FW'(BLOCK_BYTES - 1)) begin
						state_d = ST_LOAD;
					end
				end else if (fin_q) begin
					state_d = (fill_q != '0) ? ST_LOAD : ST_OUT;
				end else begin
					in_ready = !cfg_we;
					rk_ra = '0;
				end
			end
			ST_KEXP: begin
				c_step = 1'b1;
				rk_we = 1'b1;
				if (rnd_q == RK_AW'(ROUNDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD: begin
				c_load = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				c_step = 1'b1;
				rk_ra = rnd_q + 1'b1;
				if (rnd_q == RK_AW'(ROUNDS - 1)) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				chain_we = 1'b1;
				rk_ra = '0;
				state_d = fin_q ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = (state_q == ST_OUT);
	assign mac_high = chain_cur[127:64];
	assign mac_low  = chain_cur[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_high_q <= '0;
			key_low_q <= '0;
			kexp_pend_q <= 1'b1;
			fill_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			byte_ph_q <= 1'b0;
			byte_q <= '0;
			chain_zero_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_KEY_HIGH: key_high_q <= cfg_data;
					REG_KEY_LOW:  key_low_q <= cfg_data;
					default: ;
				endcase
				kexp_pend_q <= 1'b1;
			end else if (c_kexp) begin
				kexp_pend_q <= 1'b0;
			end
			if (c_load || state_q == ST_KEXP || state_q == ST_ROUND) begin
				rnd_q <= (c_load || state_d != state_q) ? '0 : rnd_q + 1'b1;
			end
			byte_ph_q <= 1'b0;
			if (in_valid && in_ready) begin
				if (opcode_t'(opcode) == OP_FINISH) begin
					fin_q <= 1'b1;
				end else begin
					byte_ph_q <= 1'b1;
					byte_q <= data_byte;
				end
			end
			if (chain_we) begin
				chain_zero_q <= 1'b0;
			end
			if (byte_ph_q && state_q == ST_IDLE && !(kexp_pend_q && !cfg_we)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == ST_OUT && out_ready) begin
				fin_q <= 1'b0;
				fill_q <= '0;
				chain_zero_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/sm4cm_checker.sv -----
// Port-level checker for the SM4 CBC-MAC engine, bound to the top level.
`timescale 1ns / 1ps
module sm4cm_checker
	import sm4cm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] mac_high,
	input logic [63:0] mac_low
);

	// No item is taken while a result waits.
	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	// A result is held stable until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mac_high) && $stable(mac_low))
		else $error("result changed while stalled");

	// An absorb item is never directly followed by a result.
	a_absorb_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_ABSORB |=> !out_valid)
		else $error("result after absorb");

	// After reset the block is busy expanding the key.
	a_reset_busy: assert property (@(posedge clk) $rose(arst_n) |-> !in_ready)
		else $error("ready immediately after reset");

endmodule

bind sm4_cbc_mac_engine sm4cm_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.opcode(opcode), .out_valid(out_valid), .out_ready(out_ready),
	.mac_high(mac_high), .mac_low(mac_low)
);
